@@ hdl/dag_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dag_pkg
// Shared types and constants for the distance attenuation gain core.
// ----------------------------------------------------------------------------
package dag_pkg;

  // Item payloads
  typedef struct packed {
    logic [31:0] dist_sq;
    logic        listener_present;
    logic [15:0] play_gain;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_gain;
    logic [15:0] attenuation;
    logic        inaudible;
  } out_item_t;

  // Register map (word index)
  localparam int unsigned RegIdxW = 3;
  localparam logic [RegIdxW-1:0] RegMinRadius = 3'd0;
  localparam logic [RegIdxW-1:0] RegRollIn    = 3'd1;
  localparam logic [RegIdxW-1:0] RegRollOut   = 3'd2;
  localparam logic [RegIdxW-1:0] RegMaxRadius = 3'd3;
  localparam logic [RegIdxW-1:0] RegRiseCf    = 3'd4;
  localparam logic [RegIdxW-1:0] RegFallCf    = 3'd5;
  localparam logic [RegIdxW-1:0] RegBaseGain  = 3'd6;
  localparam logic [RegIdxW-1:0] RegPosMode   = 3'd7;
  localparam int unsigned AddrW = RegIdxW + 2;

  // Curve segment
  typedef enum logic [1:0] {
    SEG_RISE = 2'd0,
    SEG_FALL = 2'd1,
    SEG_FLAT = 2'd2
  } seg_e;

  // Fixed point
  localparam logic [15:0] AttOne   = 16'd32768;
  localparam logic [15:0] GainMax  = 16'hFFFF;
  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned DivSteps  = 16;
  localparam int unsigned DenW      = 33;
  localparam int unsigned RemW      = 40;
  localparam int unsigned DivShW    = DenW + DivSteps - 1;
  localparam int unsigned ProdW     = 48;
  localparam int unsigned GainShift = 27;

  // Accept edge to result accept edge
  localparam int unsigned Latency = 1 + SqrtSteps + 3 + DivSteps + 3;

  // Side data carried alongside the arithmetic
  typedef struct packed {
    logic        kill;
    seg_e        seg;
    logic [31:0] bu;
  } side_t;

endpackage
`default_nettype wire

@@ hdl/distance_attenuation_gain_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// distance_attenuation_gain_core
// Per-voice gain with distance rolloff, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   An item (squared distance, listener flag, user gain) is accepted on a
//   rising edge with start high and busy low. busy is always low: one item
//   may enter every cycle, sustained rate one item per clock.
//   Each result appears on out_item_o for one cycle with out_valid_o high,
//   in the order the items were accepted. The receiver cannot stall.
//   Latency is set by the pipelined square root (16 stages, one result bit
//   each) and the pipelined divider for the curve (16 stages, one quotient
//   bit each), plus entry, segment, denominator, dividend, attenuation,
//   multiply and output stages.
//   Write registers over the APB port only while no item is in flight;
//   the block does not enforce it. Reset clears all valid bits and loads
//   register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module distance_attenuation_gain_core (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire dag_pkg::in_item_t       in_item_i,
  output logic                         out_valid_o,
  output dag_pkg::out_item_t           out_item_o,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [dag_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned NS = dag_pkg::SqrtSteps;
  localparam int unsigned ND = dag_pkg::DivSteps;

  // Configuration registers
  logic [15:0] min_q, rin_q, rout_q, max_q, rcf_q, fcf_q, bg_q;
  logic        pos_q;
  logic [31:0] min_sq_q, max_sq_q;
  logic        wr_en;
  logic [dag_pkg::RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[dag_pkg::AddrW-1:2];

  // Radius squares are taken with the radius write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= 16'd0;
      rin_q    <= 16'd0;
      rout_q   <= 16'hFFFF;
      max_q    <= 16'hFFFF;
      rcf_q    <= 16'd256;
      fcf_q    <= 16'd256;
      bg_q     <= 16'd4096;
      pos_q    <= 1'b0;
      min_sq_q <= 32'd0;
      max_sq_q <= 32'hFFFE0001;
    end else if (wr_en) begin
      unique case (reg_idx)
        dag_pkg::RegMinRadius: begin
          min_q    <= pwdata[15:0];
          min_sq_q <= pwdata[15:0] * pwdata[15:0];
        end
        dag_pkg::RegRollIn:    rin_q  <= pwdata[15:0];
        dag_pkg::RegRollOut:   rout_q <= pwdata[15:0];
        dag_pkg::RegMaxRadius: begin
          max_q    <= pwdata[15:0];
          max_sq_q <= pwdata[15:0] * pwdata[15:0];
        end
        dag_pkg::RegRiseCf:    rcf_q  <= pwdata[15:0];
        dag_pkg::RegFallCf:    fcf_q  <= pwdata[15:0];
        dag_pkg::RegBaseGain:  bg_q   <= pwdata[15:0];
        dag_pkg::RegPosMode:   pos_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      dag_pkg::RegMinRadius: prdata = {16'd0, min_q};
      dag_pkg::RegRollIn:    prdata = {16'd0, rin_q};
      dag_pkg::RegRollOut:   prdata = {16'd0, rout_q};
      dag_pkg::RegMaxRadius: prdata = {16'd0, max_q};
      dag_pkg::RegRiseCf:    prdata = {16'd0, rcf_q};
      dag_pkg::RegFallCf:    prdata = {16'd0, fcf_q};
      dag_pkg::RegBaseGain:  prdata = {16'd0, bg_q};
      dag_pkg::RegPosMode:   prdata = {31'd0, pos_q};
      default:               prdata = 32'd0;
    endcase
  end

  // Entry stage: radius test and base*user gain
  logic            accept;
  logic            outside;
  dag_pkg::side_t  side_in;
  assign accept  = start & ~busy;
  assign outside = (in_item_i.dist_sq < min_sq_q) ||
                   (in_item_i.dist_sq > max_sq_q);
  always_comb begin
    side_in      = '0;
    side_in.kill = pos_q & (~in_item_i.listener_present | outside);
    side_in.seg  = dag_pkg::SEG_FLAT;
    side_in.bu   = bg_q * in_item_i.play_gain;
  end

  // Square root pipeline, one result bit per stage
  logic [31:0]    sq_v_q [0:NS];
  logic [31:0]    sq_r_q [0:NS];
  dag_pkg::side_t sq_s_q [0:NS];
  logic           sq_vld_q [0:NS];
  logic [31:0]    sq_v_d [1:NS];
  logic [31:0]    sq_r_d [1:NS];

  always_comb begin
    logic [31:0] bitv;
    logic [31:0] trial;
    for (int k = 0; k < NS; k++) begin
      bitv  = 32'd1 << (5'(30 - 2 * k));
      trial = sq_r_q[k] + bitv;
      if (sq_v_q[k] >= trial) begin
        sq_v_d[k+1] = sq_v_q[k] - trial;
        sq_r_d[k+1] = (sq_r_q[k] >> 1) + bitv;
      end else begin
        sq_v_d[k+1] = sq_v_q[k];
        sq_r_d[k+1] = sq_r_q[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) sq_vld_q[k] <= 1'b0;
    end else begin
      sq_vld_q[0] <= accept;
      for (int k = 1; k <= NS; k++) sq_vld_q[k] <= sq_vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sq_v_q[0] <= in_item_i.dist_sq;
    sq_r_q[0] <= 32'd0;
    sq_s_q[0] <= side_in;
    for (int k = 1; k <= NS; k++) begin
      sq_v_q[k] <= sq_v_d[k];
      sq_r_q[k] <= sq_r_d[k];
      sq_s_q[k] <= sq_s_q[k-1];
    end
  end

  // Segment stage: pick rise, fall or flat
  logic [15:0]    root_d;
  logic [15:0]    sg_d_d, sg_rng_d, sg_cf_d;
  dag_pkg::side_t sg_s_d;
  logic [15:0]    sg_d_q, sg_rng_q, sg_cf_q;
  dag_pkg::side_t sg_s_q;
  logic           sg_vld_q;

  assign root_d = sq_r_q[NS][15:0];
  always_comb begin
    sg_s_d   = sq_s_q[NS];
    sg_d_d   = 16'd0;
    sg_rng_d = 16'd0;
    sg_cf_d  = 16'd0;
    if (!pos_q) begin
      sg_s_d.seg = dag_pkg::SEG_FLAT;
    end else if (root_d < rin_q) begin
      sg_s_d.seg = dag_pkg::SEG_RISE;
      sg_d_d     = root_d - min_q;
      sg_rng_d   = rin_q - min_q;
      sg_cf_d    = rcf_q;
    end else if (root_d > rout_q) begin
      sg_s_d.seg = dag_pkg::SEG_FALL;
      sg_d_d     = root_d - rout_q;
      sg_rng_d   = max_q - rout_q;
      sg_cf_d    = fcf_q;
    end else begin
      sg_s_d.seg = dag_pkg::SEG_FLAT;
    end
  end

  always_ff @(posedge clk_i) begin
    sg_d_q   <= sg_d_d;
    sg_rng_q <= sg_rng_d;
    sg_cf_q  <= sg_cf_d;
    sg_s_q   <= sg_s_d;
  end

  // Denominator stage: cf*(range-d) + d*256
  logic [dag_pkg::DenW-1:0] dn_den_q;
  logic [15:0]              dn_d_q;
  dag_pkg::side_t           dn_s_q;
  logic                     dn_vld_q;
  logic [31:0]              dn_mul;
  assign dn_mul = sg_cf_q * (sg_rng_q - sg_d_q);

  always_ff @(posedge clk_i) begin
    dn_den_q <= {1'b0, dn_mul} + {9'd0, sg_d_q, 8'd0};
    dn_d_q   <= sg_d_q;
    dn_s_q   <= sg_s_q;
  end

  // Divider pipeline, one quotient bit per stage; stage 0 holds the
  // rounded dividend
  logic [dag_pkg::RemW-1:0] dv_rem_q [0:ND];
  logic [dag_pkg::DenW-1:0] dv_den_q [0:ND];
  logic [15:0]              dv_quo_q [0:ND];
  dag_pkg::side_t           dv_s_q   [0:ND];
  logic                     dv_vld_q [0:ND];
  logic [dag_pkg::RemW-1:0] dv_rem_d [1:ND];
  logic [15:0]              dv_quo_d [1:ND];

  always_comb begin
    logic [dag_pkg::DivShW-1:0] dsh;
    for (int k = 0; k < ND; k++) begin
      dsh = {{(dag_pkg::DivShW - dag_pkg::DenW){1'b0}}, dv_den_q[k]} << (ND - 1 - k);
      if ({{(dag_pkg::DivShW - dag_pkg::RemW){1'b0}}, dv_rem_q[k]} >= dsh) begin
        dv_rem_d[k+1] = dv_rem_q[k] - dsh[dag_pkg::RemW-1:0];
        dv_quo_d[k+1] = dv_quo_q[k] | (16'd1 << (ND - 1 - k));
      end else begin
        dv_rem_d[k+1] = dv_rem_q[k];
        dv_quo_d[k+1] = dv_quo_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dv_rem_q[0] <= {1'b0, dn_d_q, 23'd0} +
                   {{(dag_pkg::RemW - dag_pkg::DenW){1'b0}}, dn_den_q >> 1};
    dv_den_q[0] <= dn_den_q;
    dv_quo_q[0] <= 16'd0;
    dv_s_q[0]   <= dn_s_q;
    for (int k = 1; k <= ND; k++) begin
      dv_rem_q[k] <= dv_rem_d[k];
      dv_den_q[k] <= dv_den_q[k-1];
      dv_quo_q[k] <= dv_quo_d[k];
      dv_s_q[k]   <= dv_s_q[k-1];
    end
  end

  // Attenuation stage
  logic [15:0] crv;
  logic [15:0] at_att_d;
  logic [15:0] at_att_q;
  logic        at_inaud_q;
  logic [31:0] at_bu_q;
  logic        at_vld_q;

  always_comb begin
    if (dv_den_q[ND] == '0) begin
      crv = 16'd0;
    end else if (dv_quo_q[ND] > dag_pkg::AttOne) begin
      crv = dag_pkg::AttOne;
    end else begin
      crv = dv_quo_q[ND];
    end
    case (dv_s_q[ND].seg)
      dag_pkg::SEG_RISE: at_att_d = crv;
      dag_pkg::SEG_FALL: at_att_d = dag_pkg::AttOne - crv;
      default:           at_att_d = dag_pkg::AttOne;
    endcase
    if (dv_s_q[ND].kill) at_att_d = 16'd0;
  end

  always_ff @(posedge clk_i) begin
    at_att_q   <= at_att_d;
    at_inaud_q <= dv_s_q[ND].kill;
    at_bu_q    <= dv_s_q[ND].bu;
  end

  // Gain multiply stage
  logic [dag_pkg::ProdW-1:0] pr_prod_q;
  logic [15:0]               pr_att_q;
  logic                      pr_inaud_q;
  logic                      pr_vld_q;

  always_ff @(posedge clk_i) begin
    pr_prod_q  <= {16'd0, at_bu_q} * {32'd0, at_att_q};
    pr_att_q   <= at_att_q;
    pr_inaud_q <= at_inaud_q;
  end

  // Output stage: round half up, saturate
  logic [dag_pkg::ProdW-1:0] rnd;
  logic [dag_pkg::ProdW-1:0] shifted;
  dag_pkg::out_item_t        out_d;
  logic                      out_vld_q;

  always_comb begin
    rnd     = pr_prod_q + (48'd1 << (dag_pkg::GainShift - 1));
    shifted = rnd >> dag_pkg::GainShift;
    out_d.out_gain    = (shifted > {32'd0, dag_pkg::GainMax}) ? dag_pkg::GainMax
                                                               : shifted[15:0];
    out_d.attenuation = pr_att_q;
    out_d.inaudible   = pr_inaud_q;
  end

  always_ff @(posedge clk_i) begin
    out_item_o <= out_d;
  end

  // Valid bits for the post-sqrt stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sg_vld_q  <= 1'b0;
      dn_vld_q  <= 1'b0;
      for (int k = 0; k <= ND; k++) dv_vld_q[k] <= 1'b0;
      at_vld_q  <= 1'b0;
      pr_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      sg_vld_q    <= sq_vld_q[NS];
      dn_vld_q    <= sg_vld_q;
      dv_vld_q[0] <= dn_vld_q;
      for (int k = 1; k <= ND; k++) dv_vld_q[k] <= dv_vld_q[k-1];
      at_vld_q    <= dv_vld_q[ND];
      pr_vld_q    <= at_vld_q;
      out_vld_q   <= pr_vld_q;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule
`default_nettype wire

@@ hdl/dag_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dag_sva
// Port-level checks for the distance attenuation gain core.
// ----------------------------------------------------------------------------
module dag_sva (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid_o,
  input wire dag_pkg::out_item_t out_item_o
);

  // Every accepted item yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(dag_pkg::Latency) out_valid_o)
    else $error("accepted item produced no result");

  // No result without a matching accepted item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##(dag_pkg::Latency) !out_valid_o)
    else $error("result without accepted item");

  // Attenuation never exceeds unity
  a_att_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.attenuation <= dag_pkg::AttOne))
    else $error("attenuation above 1.0");

  // Inaudible results carry zero gain and zero attenuation
  a_inaudible_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.inaudible) |->
      (out_item_o.out_gain == 16'd0 && out_item_o.attenuation == 16'd0))
    else $error("inaudible result with nonzero gain");

endmodule

bind distance_attenuation_gain_core dag_sva u_dag_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .out_valid_o (out_valid_o),
  .out_item_o  (out_item_o)
);
`default_nettype wire
